// File: rtl/lsbsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LSB stego stream decoder.
// Used by the channel interfaces and the top level; depends on nothing.
package lsbsd_pkg;

    // Default geometry
    localparam int HEADER_BYTES_DEF    = 54;
    localparam int MAX_MAGIC_CHARS_DEF = 8;

    // Fixed field widths
    localparam int PIX_W      = 8;
    localparam int CHAR_W     = 8;
    localparam int WORD_W     = 32;
    localparam int BITCNT_W   = 5;
    localparam int MIDX_W     = 4;
    localparam int MLEN_W     = 4;
    localparam int PATTERN_W  = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LENGTH  = 2'd1;
    localparam logic [PATTERN_W-1:0] MAGIC_PATTERN_RST = 64'd9002;
    localparam logic [MLEN_W-1:0]    MAGIC_LENGTH_RST  = 4'd2;

    // Decode phase
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_MAGIC  = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_EXTCHR = 3'd3,
        PH_SIZE   = 3'd4,
        PH_DATA   = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    // Result kind
    typedef enum logic [2:0] {
        KIND_MAGIC_OK  = 3'd0,
        KIND_MAGIC_BAD = 3'd1,
        KIND_EXT_LEN   = 3'd2,
        KIND_EXT_CHAR  = 3'd3,
        KIND_DATA_SIZE = 3'd4,
        KIND_DATA_BYTE = 3'd5
    } t_kind;

    // One result beat
    typedef struct packed {
        t_kind              kind;
        logic [WORD_W-1:0]  value;
        logic               last;
    } t_item;

endpackage

// File: rtl/lsbsd_in_if.sv
`timescale 1ns / 1ps
// Image byte channel: valid/ready plus one file byte and its restart mark.
// Depends on lsbsd_pkg.
interface lsbsd_in_if;
    logic                        valid;
    logic                        ready;
    logic [lsbsd_pkg::PIX_W-1:0] pixel_byte;
    logic                        start_of_image;

    modport source (output valid, output pixel_byte, output start_of_image, input ready);
    modport sink   (input valid, input pixel_byte, input start_of_image, output ready);
endinterface

// File: rtl/lsbsd_out_if.sv
`timescale 1ns / 1ps
// Decoded field channel: valid/ready plus kind, value and last flag.
// Depends on lsbsd_pkg.
interface lsbsd_out_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   item_kind;
    logic [lsbsd_pkg::WORD_W-1:0] item_value;
    logic                         last;

    modport source (output valid, output item_kind, output item_value, output last,
                    input ready);
    modport sink   (input valid, input item_kind, input item_value, input last,
                    output ready);
endinterface

// File: rtl/lsbsd_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready plus register index and write data.
// Depends on lsbsd_pkg.
interface lsbsd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lsbsd_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [lsbsd_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/lsb_stego_stream_decoder_top.sv
`timescale 1ns / 1ps
// LSB stego stream decoder top level: phase tracker, bit gatherer, output stage.
// Depends on lsbsd_pkg and the lsbsd_in_if, lsbsd_out_if and lsbsd_cfg_if interfaces.

// The decoder takes one image byte per clock while i_pix.ready is high and answers in
// the same pass: the byte's bit 0 is shifted into the field being gathered and, when
// that field completes, the result is registered in the output register (or in the
// skid stage behind it). The phase and shift state update on each accepted byte.
// A one-entry skid stage sits behind the output register, so i_pix.ready drops only
// when both hold an untaken result. Bytes during the header skip, inside a field and
// after the run has ended give no result. start_of_image restarts decoding at that
// byte. Configuration writes are always taken and act at once; write them while idle.
module lsb_stego_stream_decoder_top #(
    parameter int HEADER_BYTES    = lsbsd_pkg::HEADER_BYTES_DEF,
    parameter int MAX_MAGIC_CHARS = lsbsd_pkg::MAX_MAGIC_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsbsd_in_if.sink    i_pix,
    lsbsd_out_if.source o_item,
    lsbsd_cfg_if.sink   i_cfg
);

    localparam int HDR_W = (HEADER_BYTES > 0) ? $clog2(HEADER_BYTES + 1) : 1;
    localparam int WW    = lsbsd_pkg::WORD_W;
    localparam int BCW   = lsbsd_pkg::BITCNT_W;
    localparam int MIW   = lsbsd_pkg::MIDX_W;

    // Configuration registers
    logic [lsbsd_pkg::PATTERN_W-1:0] r_pattern;
    logic [lsbsd_pkg::MLEN_W-1:0]    r_mlen;

    // Decode state
    lsbsd_pkg::t_phase r_phase, n_phase;
    logic [HDR_W-1:0]  r_hdr, n_hdr;
    logic [BCW-1:0]    r_bc, n_bc;
    logic [WW-1:0]     r_sw, n_sw;
    logic [WW-2:0]     r_rem, n_rem;
    logic [MIW-1:0]    r_midx, n_midx;
    logic              r_bad, n_bad;

    // Output stage
    logic              r_out_valid, r_skid_valid;
    lsbsd_pkg::t_item  r_out, r_skid;

    // Pass signals
    logic              acc, take, start, bit_in;
    lsbsd_pkg::t_phase c_phase, e_phase;
    logic [HDR_W-1:0]  c_hdr;
    logic [BCW-1:0]    c_bc, bc_inc;
    logic [WW-1:0]     c_sw, sw_sh;
    logic [WW-2:0]     c_rem, rem_dec, len_cnt;
    logic [MIW-1:0]    c_midx, midx_inc, n_eff;
    logic              c_bad, bad_new, hdr_skip, done8, done32, at_end, mismatch;
    logic [2:0]        k;
    logic [lsbsd_pkg::CHAR_W-1:0] want;
    logic              res_fire;
    lsbsd_pkg::t_item  res_item;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !r_skid_valid;
    assign acc         = i_pix.valid && i_pix.ready;
    assign take        = r_out_valid && o_item.ready;

    // Current state, cleared by a restart mark on this beat
    assign start   = i_pix.start_of_image;
    assign bit_in  = i_pix.pixel_byte[0];
    assign c_phase = start ? lsbsd_pkg::PH_HEADER : r_phase;
    assign c_hdr   = start ? '0 : r_hdr;
    assign c_bc    = start ? '0 : r_bc;
    assign c_sw    = start ? '0 : r_sw;
    assign c_rem   = start ? '0 : r_rem;
    assign c_midx  = start ? '0 : r_midx;
    assign c_bad   = start ? 1'b0 : r_bad;

    // Header skip falls into the magic phase on the same byte
    assign hdr_skip = (c_phase == lsbsd_pkg::PH_HEADER) && (c_hdr < HDR_W'(HEADER_BYTES));
    assign e_phase  = (c_phase == lsbsd_pkg::PH_HEADER) ? lsbsd_pkg::PH_MAGIC : c_phase;

    // Bit gatherer
    assign sw_sh   = {c_sw[WW-2:0], bit_in};
    assign bc_inc  = c_bc + BCW'(1);
    assign done8   = (bc_inc == BCW'(lsbsd_pkg::CHAR_W));
    assign done32  = (bc_inc == '0);
    assign rem_dec = c_rem - (WW-1)'(1);
    assign len_cnt = sw_sh[WW-1] ? '0 : sw_sh[WW-2:0];

    // Magic compare: character i of n sits in byte n-1-i of the pattern
    assign n_eff    = (r_mlen > MIW'(MAX_MAGIC_CHARS)) ? MIW'(MAX_MAGIC_CHARS) : r_mlen;
    assign at_end   = (c_midx >= n_eff);
    assign midx_inc = c_midx + MIW'(1);
    assign k        = 3'(n_eff - MIW'(1) - c_midx);
    assign want     = r_pattern[{k, 3'b000} +: lsbsd_pkg::CHAR_W];
    assign mismatch = (sw_sh[lsbsd_pkg::CHAR_W-1:0] != want);
    assign bad_new  = c_bad || mismatch;

    // Next decode state
    always_comb begin
        n_phase = c_phase;
        n_hdr   = c_hdr;
        n_bc    = c_bc;
        n_sw    = c_sw;
        n_rem   = c_rem;
        n_midx  = c_midx;
        n_bad   = c_bad;
        if (hdr_skip) begin
            n_hdr = c_hdr + HDR_W'(1);
        end else begin
            n_phase = e_phase;
            unique case (e_phase)
                lsbsd_pkg::PH_MAGIC: begin
                    if (at_end) begin
                        if (c_bad) begin
                            n_phase = lsbsd_pkg::PH_DONE;
                        end else begin
                            // this byte opens the extension length
                            n_phase = lsbsd_pkg::PH_EXTLEN;
                            n_sw    = sw_sh;
                            n_bc    = bc_inc;
                        end
                    end else begin
                        n_sw = done8 ? '0 : sw_sh;
                        n_bc = done8 ? '0 : bc_inc;
                        if (done8) begin
                            n_midx = midx_inc;
                            n_bad  = bad_new;
                            if (midx_inc >= n_eff) begin
                                n_phase = bad_new ? lsbsd_pkg::PH_DONE : lsbsd_pkg::PH_EXTLEN;
                            end
                        end
                    end
                end
                lsbsd_pkg::PH_EXTLEN: begin
                    n_sw = done32 ? '0 : sw_sh;
                    n_bc = done32 ? '0 : bc_inc;
                    if (done32) begin
                        n_rem   = len_cnt;
                        n_phase = (len_cnt != '0) ? lsbsd_pkg::PH_EXTCHR : lsbsd_pkg::PH_SIZE;
                    end
                end
                lsbsd_pkg::PH_EXTCHR: begin
                    n_sw = done8 ? '0 : sw_sh;
                    n_bc = done8 ? '0 : bc_inc;
                    if (done8) begin
                        n_rem = rem_dec;
                        if (rem_dec == '0) begin
                            n_phase = lsbsd_pkg::PH_SIZE;
                        end
                    end
                end
                lsbsd_pkg::PH_SIZE: begin
                    n_sw = done32 ? '0 : sw_sh;
                    n_bc = done32 ? '0 : bc_inc;
                    if (done32) begin
                        n_rem   = len_cnt;
                        n_phase = (len_cnt != '0) ? lsbsd_pkg::PH_DATA : lsbsd_pkg::PH_DONE;
                    end
                end
                lsbsd_pkg::PH_DATA: begin
                    n_sw = done8 ? '0 : sw_sh;
                    n_bc = done8 ? '0 : bc_inc;
                    if (done8) begin
                        n_rem = rem_dec;
                        if (rem_dec == '0) begin
                            n_phase = lsbsd_pkg::PH_DONE;
                        end
                    end
                end
                default: begin
                    n_phase = lsbsd_pkg::PH_DONE;
                end
            endcase
        end
    end

    // Result of this beat
    always_comb begin
        res_fire       = 1'b0;
        res_item.kind  = lsbsd_pkg::KIND_MAGIC_OK;
        res_item.value = '0;
        res_item.last  = 1'b0;
        if (!hdr_skip) begin
            unique case (e_phase)
                lsbsd_pkg::PH_MAGIC: begin
                    if (at_end) begin
                        res_fire      = 1'b1;
                        res_item.kind = c_bad ? lsbsd_pkg::KIND_MAGIC_BAD
                                              : lsbsd_pkg::KIND_MAGIC_OK;
                        res_item.last = c_bad;
                    end else if (done8 && (midx_inc >= n_eff)) begin
                        res_fire      = 1'b1;
                        res_item.kind = bad_new ? lsbsd_pkg::KIND_MAGIC_BAD
                                                : lsbsd_pkg::KIND_MAGIC_OK;
                        res_item.last = bad_new;
                    end
                end
                lsbsd_pkg::PH_EXTLEN: begin
                    res_fire       = done32;
                    res_item.kind  = lsbsd_pkg::KIND_EXT_LEN;
                    res_item.value = sw_sh;
                end
                lsbsd_pkg::PH_EXTCHR: begin
                    res_fire       = done8;
                    res_item.kind  = lsbsd_pkg::KIND_EXT_CHAR;
                    res_item.value = WW'(sw_sh[lsbsd_pkg::CHAR_W-1:0]);
                end
                lsbsd_pkg::PH_SIZE: begin
                    res_fire       = done32;
                    res_item.kind  = lsbsd_pkg::KIND_DATA_SIZE;
                    res_item.value = sw_sh;
                    res_item.last  = (len_cnt == '0);
                end
                lsbsd_pkg::PH_DATA: begin
                    res_fire       = done8;
                    res_item.kind  = lsbsd_pkg::KIND_DATA_BYTE;
                    res_item.value = WW'(sw_sh[lsbsd_pkg::CHAR_W-1:0]);
                    res_item.last  = (rem_dec == '0);
                end
                default: begin
                    res_fire = 1'b0;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= lsbsd_pkg::MAGIC_PATTERN_RST;
            r_mlen    <= lsbsd_pkg::MAGIC_LENGTH_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.reg_index == lsbsd_pkg::CFG_MAGIC_PATTERN) begin
                r_pattern <= i_cfg.wr_data;
            end
            if (i_cfg.reg_index == lsbsd_pkg::CFG_MAGIC_LENGTH) begin
                r_mlen <= i_cfg.wr_data[lsbsd_pkg::MLEN_W-1:0];
            end
        end
    end

    // Advance decode state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lsbsd_pkg::PH_HEADER;
            r_hdr   <= '0;
            r_bc    <= '0;
            r_sw    <= '0;
            r_rem   <= '0;
            r_midx  <= '0;
            r_bad   <= 1'b0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_bc    <= n_bc;
            r_sw    <= n_sw;
            r_rem   <= n_rem;
            r_midx  <= n_midx;
            r_bad   <= n_bad;
        end
    end

    // Output register and skid stage: valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            r_out_valid  <= r_skid_valid || (acc && res_fire);
            r_skid_valid <= 1'b0;
        end else if (acc && res_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output register and skid stage: payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : res_item;
        end else if (acc && res_fire) begin
            r_skid <= res_item;
        end
    end

    assign o_item.valid      = r_out_valid;
    assign o_item.item_kind  = r_out.kind;
    assign o_item.item_value = r_out.value;
    assign o_item.last       = r_out.last;

    // Skid stage fills only behind a held output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a beat while output register is empty");

    // A finished run stays silent until the next restart
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !start && r_phase == lsbsd_pkg::PH_DONE) |-> !res_fire)
        else $error("result produced after the run ended");

    // Character fields never gather more than eight bits
    a_char_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lsbsd_pkg::PH_EXTCHR || r_phase == lsbsd_pkg::PH_DATA)
        |-> (r_bc < BCW'(lsbsd_pkg::CHAR_W)))
        else $error("bit count overran a character field");

    // Magic index stays within the maximum magic length
    a_midx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_midx <= MIW'(MAX_MAGIC_CHARS))
        else $error("magic index beyond maximum magic length");

endmodule
